### src/ipv4_l4_header_extractor_defines.svh
// Assertion macros for the IPv4 L4 header extractor checker.
// Each macro expects clk_i in the scope where it is used; IPV4L4_ASSERT also rst_ni.
`ifndef IPV4_L4_HEADER_EXTRACTOR_DEFINES_SVH
`define IPV4_L4_HEADER_EXTRACTOR_DEFINES_SVH

// Checked only while out of reset.
`define IPV4L4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define IPV4L4_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/ipv4l4_pkg.sv
// Shared types and constants for the IPv4 L4 header extractor.
// No dependencies; imported by all RTL modules and the checker.
package ipv4l4_pkg;

  localparam int unsigned MAX_PKT_BYTES = 65535;
  localparam int unsigned LEN_W         = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [LEN_W-1:0] MIN_PKT_BYTES = 16'd20;
  localparam logic [LEN_W-1:0] TCP_L4_MIN    = 16'd20;
  localparam logic [LEN_W-1:0] SHORT_L4_MIN  = 16'd8;
  localparam logic [3:0]       IP_VERSION    = 4'd4;
  localparam logic [3:0]       MIN_IHL       = 4'd5;
  localparam logic [3:0]       MIN_TCP_DOFF  = 4'd5;
  localparam logic [15:0]      FRAG_MASK     = 16'h3FFF;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_NOT_V4      = 3'd2,
    ST_BAD_IHL     = 3'd3,
    ST_TOT_LONG    = 3'd4,
    ST_FRAGMENT    = 3'd5,
    ST_BAD_TCP_OFF = 3'd6,
    ST_NO_L4       = 3'd7
  } status_e;

  // Snapshot of one packet's captured header state, front to back.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [3:0]       ihl;
    logic [3:0]       version;
    logic [15:0]      ip_total;
    logic             frag;
    logic [7:0]       proto;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [31:0]      ports;
    logic [3:0]       doff;
    logic [4:0]       flags;
  } pkt_rec_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] ip_total;
    logic        frag;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [4:0]  flags;
  } result_t;

endpackage

### src/ipv4l4_intf.sv
// Valid/ready channel interfaces: packet byte stream in, parse result out.
// No dependencies.
interface ipv4l4_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ipv4l4_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [7:0]  ip_protocol;
  logic [15:0] total_length;
  logic        fragmented;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [4:0]  tcp_flag_bits;

  modport source (output valid, status, source_address, destination_address, ip_protocol,
                  total_length, fragmented, source_port, destination_port, tcp_flag_bits,
                  input ready);
  modport sink   (input valid, status, source_address, destination_address, ip_protocol,
                  total_length, fragmented, source_port, destination_port, tcp_flag_bits,
                  output ready);
endinterface

### src/ipv4_l4_header_extractor.sv
// IPv4 L4 header extractor: one byte per cycle in, one result per packet out.
// Throughput: one byte every cycle; the input stalls only when the two-entry
// record queue is full. The last byte's transfer writes the record into the queue;
// the check stage then pops it into the output register once that register is free.
// Reset (async, active low) empties the queue and clears all captured state.
module ipv4_l4_header_extractor import ipv4l4_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PKT_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ipv4l4_pkt_if.sink          pkt_i,
  ipv4l4_res_if.source        res_o
);

  logic     accept;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_avail;
  pkt_rec_t front_rec;
  pkt_rec_t q_rec;
  result_t  res;

  assign pkt_i.ready = !q_full;
  assign accept      = pkt_i.valid && pkt_i.ready;

  ipv4l4_front #(
    .MaxPacketBytes(MAX_PACKET_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (pkt_i.data_byte),
    .last_byte_i (pkt_i.last_byte),
    .push_o      (push),
    .rec_o       (front_rec)
  );

  ipv4l4_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .pop_i   (pop),
    .full_o  (q_full),
    .avail_o (q_avail),
    .rec_o   (q_rec)
  );

  ipv4l4_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_avail_i (q_avail),
    .rec_i       (q_rec),
    .pop_o       (pop),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.status              = res.status;
  assign res_o.source_address      = res.src;
  assign res_o.destination_address = res.dst;
  assign res_o.ip_protocol         = res.proto;
  assign res_o.total_length        = res.ip_total;
  assign res_o.fragmented          = res.frag;
  assign res_o.source_port         = res.sport;
  assign res_o.destination_port    = res.dport;
  assign res_o.tcp_flag_bits       = res.flags;

endmodule

### src/ipv4l4_front.sv
// Front end: counts bytes and captures IPv4 and transport header fields.
// Pushes a packet record on the last byte. Depends on ipv4l4_pkg.
module ipv4l4_front import ipv4l4_pkg::*; #(
  parameter int unsigned MaxPacketBytes = MAX_PKT_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       push_o,
  output pkt_rec_t   rec_o
);

  localparam int unsigned      CntW   = $clog2(MaxPacketBytes + 1);
  localparam logic [CntW-1:0]  CntMax = CntW'(MaxPacketBytes);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [3:0]      ihl_q, ihl_d;
  logic [3:0]      ver_q, ver_d;
  logic [15:0]     tot_q, tot_d;
  logic [15:0]     frag_q, frag_d;
  logic [7:0]      proto_q, proto_d;
  logic [31:0]     src_q, src_d;
  logic [31:0]     dst_q, dst_d;
  logic [31:0]     ports_q, ports_d;
  logic [3:0]      doff_q, doff_d;
  logic [4:0]      flags_q, flags_d;

  logic [LEN_W-1:0] pos;
  logic [LEN_W-1:0] hdr;
  logic [LEN_W-1:0] rel;

  assign pos = LEN_W'(cnt_q);
  assign hdr = LEN_W'({ihl_q, 2'b00});
  assign rel = pos - hdr;

  always_comb begin
    cnt_d   = cnt_q;
    ihl_d   = ihl_q;
    ver_d   = ver_q;
    tot_d   = tot_q;
    frag_d  = frag_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    ports_d = ports_q;
    doff_d  = doff_q;
    flags_d = flags_q;
    // bytes past the saturation point are neither counted nor captured
    if (cnt_q != CntMax) begin
      cnt_d = cnt_q + 1'b1;
      priority if (pos == 16'd0) begin
        ver_d = data_byte_i[7:4];
        ihl_d = data_byte_i[3:0];
      end else if (pos == 16'd2 || pos == 16'd3) begin
        tot_d = {tot_q[7:0], data_byte_i};
      end else if (pos == 16'd6 || pos == 16'd7) begin
        frag_d = {frag_q[7:0], data_byte_i};
      end else if (pos == 16'd9) begin
        proto_d = data_byte_i;
      end else if (pos >= 16'd12 && pos <= 16'd15) begin
        src_d = {src_q[23:0], data_byte_i};
      end else if (pos >= 16'd16 && pos <= 16'd19) begin
        dst_d = {dst_q[23:0], data_byte_i};
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
      // transport header starts at ihl*4, always past the IPv4 fixed header
      if (ihl_q >= MIN_IHL && pos >= hdr) begin
        priority if (rel <= 16'd3) begin
          ports_d = {ports_q[23:0], data_byte_i};
        end else if (rel == 16'd12) begin
          doff_d = data_byte_i[7:4];
        end else if (rel == 16'd13) begin
          flags_d = data_byte_i[4:0];
        end else begin
          ports_d = ports_q;
        end
      end
    end
  end

  assign push_o = accept_i & last_byte_i;

  always_comb begin
    rec_o.len      = LEN_W'(cnt_d);
    rec_o.ihl      = ihl_d;
    rec_o.version  = ver_d;
    rec_o.ip_total = tot_d;
    rec_o.frag     = |(frag_d & FRAG_MASK);
    rec_o.proto    = proto_d;
    rec_o.src      = src_d;
    rec_o.dst      = dst_d;
    rec_o.ports    = ports_d;
    rec_o.doff     = doff_d;
    rec_o.flags    = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ihl_q   <= '0;
      ver_q   <= '0;
      tot_q   <= '0;
      frag_q  <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      ports_q <= '0;
      doff_q  <= '0;
      flags_q <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        cnt_q   <= '0;
        ihl_q   <= '0;
        ver_q   <= '0;
        tot_q   <= '0;
        frag_q  <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        ports_q <= '0;
        doff_q  <= '0;
        flags_q <= '0;
      end else begin
        cnt_q   <= cnt_d;
        ihl_q   <= ihl_d;
        ver_q   <= ver_d;
        tot_q   <= tot_d;
        frag_q  <= frag_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        ports_q <= ports_d;
        doff_q  <= doff_d;
        flags_q <= flags_d;
      end
    end
  end

endmodule

### src/ipv4l4_queue.sv
// Short FIFO of packet records between front end and back end.
// Depends on ipv4l4_pkg.
module ipv4l4_queue import ipv4l4_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pkt_rec_t rec_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     avail_o,
  output pkt_rec_t rec_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  pkt_rec_t        mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/ipv4l4_back.sv
// Back end: runs the packet checks on a record and holds the result register.
// Depends on ipv4l4_pkg.
module ipv4l4_back import ipv4l4_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rec_avail_i,
  input  pkt_rec_t rec_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output result_t  res_o
);

  logic             valid_q;
  result_t          res_q, res_d;
  logic [LEN_W-1:0] hdr;
  logic [LEN_W-1:0] l4;
  logic [LEN_W-1:0] doff_bytes;

  assign hdr        = LEN_W'({rec_i.ihl, 2'b00});
  assign l4         = rec_i.len - hdr;
  assign doff_bytes = LEN_W'({rec_i.doff, 2'b00});

  // check order: short, version, ihl, total length, fragment, transport
  always_comb begin
    res_d        = '0;
    res_d.status = ST_OK;
    priority if (rec_i.len < MIN_PKT_BYTES) begin
      res_d.status = ST_SHORT;
    end else if (rec_i.version != IP_VERSION) begin
      res_d.status = ST_NOT_V4;
    end else if (rec_i.ihl < MIN_IHL || rec_i.len < hdr) begin
      res_d.status = ST_BAD_IHL;
    end else begin
      res_d.src      = rec_i.src;
      res_d.dst      = rec_i.dst;
      res_d.proto    = rec_i.proto;
      res_d.ip_total = rec_i.ip_total;
      priority if (rec_i.ip_total > rec_i.len) begin
        res_d.status = ST_TOT_LONG;
      end else if (rec_i.frag) begin
        res_d.frag   = 1'b1;
        res_d.status = ST_FRAGMENT;
      end else if (rec_i.proto == PROTO_TCP && l4 >= TCP_L4_MIN) begin
        if (rec_i.doff < MIN_TCP_DOFF || doff_bytes > l4) begin
          res_d.status = ST_BAD_TCP_OFF;
        end else begin
          res_d.sport = rec_i.ports[31:16];
          res_d.dport = rec_i.ports[15:0];
          res_d.flags = rec_i.flags;
        end
      end else if (rec_i.proto == PROTO_UDP && l4 >= SHORT_L4_MIN) begin
        res_d.sport = rec_i.ports[31:16];
        res_d.dport = rec_i.ports[15:0];
      end else if (rec_i.proto == PROTO_ICMP && l4 >= SHORT_L4_MIN) begin
        res_d.status = ST_OK;
      end else begin
        res_d.status = ST_NO_L4;
      end
    end
  end

  assign pop_o       = rec_avail_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

### src/ipv4l4_checker.sv
// Port-level checker for the IPv4 L4 header extractor, bound to the top level.
// Depends on ipv4l4_pkg, the channel interfaces and the assertion macro header.
`include "ipv4_l4_header_extractor_defines.svh"

module ipv4l4_checker import ipv4l4_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  ipv4l4_pkt_if.sink   pkt_i,
  ipv4l4_res_if.source res_o
);

  localparam int unsigned PendW = $clog2(QUEUE_DEPTH + 2);

  logic             last_xfer;
  logic             res_xfer;
  logic [PendW-1:0] pend_q;

  assign last_xfer = pkt_i.valid && pkt_i.ready && pkt_i.last_byte;
  assign res_xfer  = res_o.valid && res_o.ready;

  // packets whose last byte was taken but whose result is not yet out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (last_xfer && !res_xfer) begin
      pend_q <= pend_q + 1'b1;
    end else if (res_xfer && !last_xfer) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  `IPV4L4_ASSERT(a_res_hold, res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.status) && $stable(res_o.source_port), "result changed while stalled")
  `IPV4L4_ASSERT_RST(a_rst_idle, !rst_ni |-> !res_o.valid, "result valid during reset")
  `IPV4L4_ASSERT(a_no_orphan, res_o.valid |-> pend_q != '0, "result without a packet")
  `IPV4L4_ASSERT(a_early_zero, res_o.valid && (res_o.status == ST_SHORT || res_o.status == ST_NOT_V4 || res_o.status == ST_BAD_IHL) |-> res_o.source_address == 32'd0 && res_o.ip_protocol == 8'd0 && res_o.total_length == 16'd0 && res_o.source_port == 16'd0, "early reject with fields set")
  `IPV4L4_ASSERT(a_flags_tcp, res_o.valid && res_o.tcp_flag_bits != 5'd0 |-> res_o.status == ST_OK && res_o.ip_protocol == PROTO_TCP, "TCP flags on a non-TCP result")

endmodule

bind ipv4_l4_header_extractor ipv4l4_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .pkt_i  (pkt_i),
  .res_o  (res_o)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for ipv4_l4_header_extractor: directed packets, then random ones.
// Needs ipv4l4_pkg and the ipv4l4_pkt_if / ipv4l4_res_if channel interfaces.
module tb_top;
  import ipv4l4_pkg::*;

  // One packet description. tot < 0 puts the packet length in the total length field.
  typedef struct {
    int unsigned nbytes;
    logic [7:0]  vihl;
    int          tot;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [7:0]  doff_b;
    logic [7:0]  flag_b;
    bit          typed;
    status_e     want_st;
  } pkt_row_t;

  localparam int N_DIR = 27;

  // Typed rows: the status alone, every other field reads as zero.
  pkt_row_t dir_rows [N_DIR] = '{
    '{19,    8'h45, -1,    16'h0000, PROTO_UDP,  8'h50, 8'h00, 1'b1, ST_SHORT},
    '{1,     8'h45, -1,    16'h0000, PROTO_UDP,  8'h50, 8'h00, 1'b1, ST_SHORT},
    '{20,    8'h65, -1,    16'h0000, PROTO_UDP,  8'h50, 8'h00, 1'b1, ST_NOT_V4},
    '{20,    8'h00, -1,    16'h0000, PROTO_UDP,  8'h50, 8'h00, 1'b1, ST_NOT_V4},
    '{60,    8'hFF, -1,    16'h0000, PROTO_TCP,  8'h50, 8'h00, 1'b1, ST_NOT_V4},
    '{40,    8'h44, -1,    16'h0000, PROTO_UDP,  8'h50, 8'h00, 1'b1, ST_BAD_IHL},
    '{40,    8'h40, -1,    16'h0000, PROTO_UDP,  8'h50, 8'h00, 1'b1, ST_BAD_IHL},
    '{40,    8'h4F, -1,    16'h0000, PROTO_UDP,  8'h50, 8'h00, 1'b1, ST_BAD_IHL},
    '{28,    8'h45, 29,    16'h0000, PROTO_UDP,  8'h50, 8'h00, 1'b0, ST_OK},
    '{40,    8'h45, 65535, 16'h0000, PROTO_TCP,  8'h50, 8'h00, 1'b0, ST_OK},
    '{28,    8'h45, -1,    16'h2000, PROTO_UDP,  8'h50, 8'h00, 1'b0, ST_OK},
    '{28,    8'h45, -1,    16'h0001, PROTO_UDP,  8'h50, 8'h00, 1'b0, ST_OK},
    '{28,    8'h45, -1,    16'hFFFF, PROTO_UDP,  8'h50, 8'h00, 1'b0, ST_OK},
    '{28,    8'h45, -1,    16'h4000, PROTO_UDP,  8'h50, 8'h00, 1'b0, ST_OK},
    '{20,    8'h45, 0,     16'h0000, PROTO_UDP,  8'h50, 8'h00, 1'b0, ST_OK},
    '{27,    8'h45, -1,    16'h0000, PROTO_UDP,  8'h50, 8'h00, 1'b0, ST_OK},
    '{28,    8'h45, -1,    16'h0000, PROTO_ICMP, 8'h50, 8'h00, 1'b0, ST_OK},
    '{27,    8'h45, -1,    16'h0000, PROTO_ICMP, 8'h50, 8'h00, 1'b0, ST_OK},
    '{40,    8'h45, -1,    16'h0000, PROTO_TCP,  8'h5F, 8'hFF, 1'b0, ST_OK},
    '{39,    8'h45, -1,    16'h0000, PROTO_TCP,  8'h50, 8'h1F, 1'b0, ST_OK},
    '{40,    8'h45, -1,    16'h0000, PROTO_TCP,  8'h40, 8'h02, 1'b0, ST_OK},
    '{40,    8'h45, -1,    16'h0000, PROTO_TCP,  8'hF0, 8'h10, 1'b0, ST_OK},
    '{80,    8'h45, -1,    16'h0000, PROTO_TCP,  8'hF0, 8'h00, 1'b0, ST_OK},
    '{28,    8'h45, -1,    16'h0000, 8'hFF,      8'h50, 8'h00, 1'b0, ST_OK},
    '{44,    8'h46, -1,    16'h0000, PROTO_TCP,  8'h60, 8'h12, 1'b0, ST_OK},
    '{68,    8'h4F, -1,    16'h0000, PROTO_UDP,  8'h50, 8'h00, 1'b0, ST_OK},
    '{60,    8'h4F, -1,    16'h0000, PROTO_UDP,  8'h50, 8'h00, 1'b0, ST_OK}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ipv4l4_pkt_if pkt_if ();
  ipv4l4_res_if res_if ();

  ipv4_l4_header_extractor i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pkt_i  (pkt_if),
    .res_o  (res_if)
  );

  always #2 clk_i = ~clk_i;

  // Header capture state of the packet in flight.
  int unsigned cap_count;
  logic [3:0]  cap_ihl, cap_ver;
  logic [15:0] cap_tot, cap_frag;
  logic [7:0]  cap_proto;
  logic [31:0] cap_src, cap_dst, cap_ports;
  logic [11:0] cap_offl;

  result_t     hdr_results_q [$];
  int          n_err;
  bit          quiet, calm;
  int unsigned bytes_sent;

  function automatic void clear_capture();
    cap_count = 0;
    cap_ihl   = '0;
    cap_ver   = '0;
    cap_tot   = '0;
    cap_frag  = '0;
    cap_proto = '0;
    cap_src   = '0;
    cap_dst   = '0;
    cap_ports = '0;
    cap_offl  = '0;
  endfunction

  // Consumes one accepted byte; returns 1 with the parse result on the last byte.
  function automatic bit parse_byte(input logic [7:0] b, input bit lst, output result_t r);
    int unsigned pos, hdr, len, l4, rel, doff4;
    r = '0;
    if (cap_count < MAX_PKT_BYTES) begin
      pos = cap_count;
      case (pos)
        0: begin
          cap_ver = b[7:4];
          cap_ihl = b[3:0];
        end
        2, 3:           cap_tot = {cap_tot[7:0], b};
        6, 7:           cap_frag = {cap_frag[7:0], b};
        9:              cap_proto = b;
        12, 13, 14, 15: cap_src = {cap_src[23:0], b};
        16, 17, 18, 19: cap_dst = {cap_dst[23:0], b};
        default: ;
      endcase
      hdr = cap_ihl * 4;
      if (cap_ihl >= MIN_IHL && pos >= hdr) begin
        rel = pos - hdr;
        if (rel <= 3)       cap_ports = {cap_ports[23:0], b};
        else if (rel == 12) cap_offl[11:8] = b[7:4];
        else if (rel == 13) cap_offl[7:0] = b;
      end
      cap_count++;
    end
    if (!lst) return 1'b0;

    len = cap_count;
    hdr = cap_ihl * 4;
    if (len < MIN_PKT_BYTES) begin
      r.status = ST_SHORT;
    end else if (cap_ver != IP_VERSION) begin
      r.status = ST_NOT_V4;
    end else if (cap_ihl < MIN_IHL || len < hdr) begin
      r.status = ST_BAD_IHL;
    end else begin
      r.src      = cap_src;
      r.dst      = cap_dst;
      r.proto    = cap_proto;
      r.ip_total = cap_tot;
      l4 = len - hdr;
      if (cap_tot > len) begin
        r.status = ST_TOT_LONG;
      end else if ((cap_frag & FRAG_MASK) != 0) begin
        r.frag   = 1'b1;
        r.status = ST_FRAGMENT;
      end else if (cap_proto == PROTO_TCP && l4 >= TCP_L4_MIN) begin
        doff4 = cap_offl[11:8] * 4;
        if (cap_offl[11:8] < MIN_TCP_DOFF || doff4 > l4) begin
          r.status = ST_BAD_TCP_OFF;
        end else begin
          r.sport = cap_ports[31:16];
          r.dport = cap_ports[15:0];
          r.flags = cap_offl[4:0];
        end
      end else if (cap_proto == PROTO_UDP && l4 >= SHORT_L4_MIN) begin
        r.sport = cap_ports[31:16];
        r.dport = cap_ports[15:0];
      end else if (cap_proto == PROTO_ICMP && l4 >= SHORT_L4_MIN) begin
        r.status = ST_OK;
      end else begin
        r.status = ST_NO_L4;
      end
    end
    clear_capture();
    return 1'b1;
  endfunction

  task automatic report(input string what, input result_t want, input result_t got);
    if (n_err < 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  exp st=%0d src=%h dst=%h pr=%0d tot=%0d fr=%0d sp=%0d dp=%0d fl=%h",
               want.status, want.src, want.dst, want.proto, want.ip_total, want.frag,
               want.sport, want.dport, want.flags);
      $display("  got st=%0d src=%h dst=%h pr=%0d tot=%0d fr=%0d sp=%0d dp=%0d fl=%h",
               got.status, got.src, got.dst, got.proto, got.ip_total, got.frag,
               got.sport, got.dport, got.flags);
    end
    n_err++;
  endtask

  function automatic void poke(ref logic [7:0] f [], input int unsigned k, input logic [7:0] v);
    if (k < f.size()) f[k] = v;
  endfunction

  // Drives one byte and waits for its transfer; called at a rising edge.
  task automatic put_byte(input logic [7:0] b, input bit lst, output bit done,
                          output result_t r);
    pkt_if.valid     <= 1'b1;
    pkt_if.data_byte <= b;
    pkt_if.last_byte <= lst;
    @(posedge clk_i);
    while (!pkt_if.ready) @(posedge clk_i);
    done = parse_byte(b, lst, r);
  endtask

  task automatic send_packet(input pkt_row_t row, input bit noise);
    logic [7:0]  frame [];
    logic [15:0] tl;
    int unsigned hdr;
    bit          done;
    result_t     r, typed_r;
    frame = new[row.nbytes];
    foreach (frame[i]) frame[i] = 8'($urandom);
    if (!noise) begin
      tl = (row.tot < 0) ? 16'(row.nbytes) : 16'(row.tot);
      poke(frame, 0, row.vihl);
      poke(frame, 2, tl[15:8]);
      poke(frame, 3, tl[7:0]);
      poke(frame, 6, row.frag[15:8]);
      poke(frame, 7, row.frag[7:0]);
      poke(frame, 9, row.proto);
      hdr = row.vihl[3:0] * 4;
      if (row.vihl[3:0] >= MIN_IHL) begin
        poke(frame, hdr + 12, row.doff_b);
        poke(frame, hdr + 13, row.flag_b);
      end
    end
    foreach (frame[i]) begin
      if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
        pkt_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      put_byte(frame[i], i == frame.size() - 1, done, r);
      bytes_sent++;
      if (done) begin
        typed_r        = '0;
        typed_r.status = row.want_st;
        hdr_results_q.push_back(row.typed ? typed_r : r);
      end
    end
  endtask

  // Mostly well-formed IPv4 packets with random content; some raw noise.
  function automatic pkt_row_t random_packet(output bit noise);
    pkt_row_t    p;
    int unsigned ihl, l4, doff, sel;
    p       = '{want_st: ST_OK, default: 0};
    p.typed = 1'b0;
    noise   = ($urandom_range(0, 99) < 12);
    if (noise) begin
      p.nbytes = $urandom_range(1, 80);
      return p;
    end
    ihl    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
    p.vihl = {($urandom_range(0, 19) == 0) ? 4'($urandom) : IP_VERSION, 4'(ihl)};
    sel    = $urandom_range(0, 9);
    doff   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
    p.doff_b = {4'(doff), 4'($urandom)};
    p.flag_b = 8'($urandom);
    if (sel <= 3) begin
      p.proto = PROTO_TCP;
      l4 = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 30) : doff * 4 + $urandom_range(0, 16);
    end else begin
      if (sel <= 6)      p.proto = PROTO_UDP;
      else if (sel <= 8) p.proto = PROTO_ICMP;
      else               p.proto = 8'($urandom);
      l4 = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 10) : $urandom_range(8, 32);
    end
    p.nbytes = ((ihl < 5) ? 20 : ihl * 4) + l4;
    if (p.nbytes == 0) p.nbytes = 1;
    case ($urandom_range(0, 9))
      0:       p.tot = $urandom_range(0, p.nbytes);
      1:       p.tot = p.nbytes + $urandom_range(1, 100);
      2:       p.tot = $urandom_range(0, 65535);
      default: p.tot = -1;
    endcase
    case ($urandom_range(0, 9))
      0, 1:    p.frag = 16'h4000;
      2:       p.frag = 16'($urandom);
      3:       p.frag = 16'(1 << $urandom_range(0, 13));
      default: p.frag = 16'h0000;
    endcase
    return p;
  endfunction

  // Result sink with random back-pressure.
  initial begin
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (quiet || calm) begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : res_check
    result_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.status   = status_e'(res_if.status);
      got.src      = res_if.source_address;
      got.dst      = res_if.destination_address;
      got.proto    = res_if.ip_protocol;
      got.ip_total = res_if.total_length;
      got.frag     = res_if.fragmented;
      got.sport    = res_if.source_port;
      got.dport    = res_if.destination_port;
      got.flags    = res_if.tcp_flag_bits;
      if (hdr_results_q.size() == 0) begin
        report("result transfer with nothing expected", '0, got);
      end else begin
        want = hdr_results_q.pop_front();
        if (got.status !== want.status || got.src !== want.src || got.dst !== want.dst ||
            got.proto !== want.proto || got.ip_total !== want.ip_total ||
            got.frag !== want.frag || got.sport !== want.sport ||
            got.dport !== want.dport || got.flags !== want.flags)
          report("result mismatch", want, got);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    pkt_row_t p;
    bit       noise;
    n_err      = 0;
    quiet      = 1'b0;
    calm       = 1'b0;
    bytes_sent = 0;
    clear_capture();
    rst_ni           <= 1'b0;
    pkt_if.valid     <= 1'b0;
    pkt_if.data_byte <= '0;
    pkt_if.last_byte <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_packet(dir_rows[i], 1'b0);

    while (bytes_sent < 1250) begin
      calm  = ($urandom_range(0, 4) == 0);
      quiet = (bytes_sent >= 1050);
      p = random_packet(noise);
      send_packet(p, noise);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        pkt_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    pkt_if.valid <= 1'b0;

    while (hdr_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/ipv4l4_pkg.sv
src/ipv4l4_intf.sv
src/ipv4l4_front.sv
src/ipv4l4_queue.sv
src/ipv4l4_back.sv
src/ipv4_l4_header_extractor.sv
src/ipv4l4_checker.sv
test/tb_top.sv
